>>> rtl/scfnc_pkg.sv
// Shared types and constants for the nested comment filter.
`default_nettype none
package scfnc_pkg;

  localparam int LINE_W    = 24;
  localparam int COL_W     = 16;
  localparam int MAX_DEPTH = 255;
  localparam int DEPTH_W   = $clog2(MAX_DEPTH + 1);

  localparam int MIDQ_DEPTH = 2;
  localparam int MIDQ_AW    = $clog2(MIDQ_DEPTH);
  localparam int MIDQ_CW    = $clog2(MIDQ_DEPTH + 1);
  localparam int OUTQ_DEPTH = 4;
  localparam int OUTQ_AW    = $clog2(OUTQ_DEPTH);
  localparam int OUTQ_CW    = $clog2(OUTQ_DEPTH + 1);

  localparam logic [LINE_W-1:0] LINE_TOP = {LINE_W{1'b1}};
  localparam logic [COL_W-1:0]  COL_TOP  = {COL_W{1'b1}};

  localparam logic [7:0] CH_LF = 8'd10;
  localparam logic [7:0] CH_CR = 8'd13;

  localparam logic [7:0] OPEN_FIRST_RST   = 8'd40;
  localparam logic [7:0] OPEN_SECOND_RST  = 8'd42;
  localparam logic [7:0] CLOSE_FIRST_RST  = 8'd42;
  localparam logic [7:0] CLOSE_SECOND_RST = 8'd41;

  typedef enum logic [1:0] {
    CFG_OPEN_FIRST   = 2'd0,
    CFG_OPEN_SECOND  = 2'd1,
    CFG_CLOSE_FIRST  = 2'd2,
    CFG_CLOSE_SECOND = 2'd3
  } cfg_idx_t;

  typedef enum logic [1:0] {
    KIND_CHAR     = 2'd0,
    KIND_END      = 2'd1,
    KIND_EOF_CMT  = 2'd2,
    KIND_TOO_DEEP = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    MODE_PLAIN  = 2'd0,
    MODE_CMT    = 2'd1,
    MODE_CLOSE1 = 2'd2,
    MODE_OPEN1  = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    NL_NONE = 2'd0,
    NL_CR   = 2'd1,
    NL_LF   = 2'd2
  } nl_t;

  typedef struct packed {
    logic       is_end;
    logic       is_cr;
    logic       is_lf;
    logic       m_of;
    logic       m_os;
    logic       m_cf;
    logic       m_cs;
    logic [7:0] ch;
    logic [7:0] of_val;
  } item_t;

  typedef struct packed {
    logic [7:0]        ch;
    logic [LINE_W-1:0] line;
    logic [COL_W-1:0]  col;
    kind_t             kind;
    logic              last;
  } result_t;

endpackage
`default_nettype wire

>>> rtl/scfnc_front.sv
// Front part: marker registers and byte classification.
`default_nettype none
module scfnc_front (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_we,
  input  wire logic [1:0]           cfg_index,
  input  wire logic [7:0]           cfg_data,
  input  wire logic [7:0]           in_byte,
  input  wire logic                 in_end,
  output scfnc_pkg::item_t          item
);
  import scfnc_pkg::*;

  logic [7:0] open_first_r, open_second_r, close_first_r, close_second_r;
  logic [7:0] folded;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      open_first_r   <= OPEN_FIRST_RST;
      open_second_r  <= OPEN_SECOND_RST;
      close_first_r  <= CLOSE_FIRST_RST;
      close_second_r <= CLOSE_SECOND_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_OPEN_FIRST:   open_first_r   <= cfg_data;
        CFG_OPEN_SECOND:  open_second_r  <= cfg_data;
        CFG_CLOSE_FIRST:  close_first_r  <= cfg_data;
        CFG_CLOSE_SECOND: close_second_r <= cfg_data;
        default: ;
      endcase
    end
  end

  assign folded = (in_byte == CH_CR) ? CH_LF : in_byte;

  always_comb begin
    item.is_end = in_end;
    item.is_cr  = (in_byte == CH_CR);
    item.is_lf  = (in_byte == CH_LF);
    item.m_of   = (folded == open_first_r);
    item.m_os   = (folded == open_second_r);
    item.m_cf   = (folded == close_first_r);
    item.m_cs   = (folded == close_second_r);
    item.ch     = folded;
    item.of_val = open_first_r;
  end

endmodule
`default_nettype wire

>>> rtl/scfnc_midq.sv
// Short queue of classified items between the front and back parts.
`default_nettype none
module scfnc_midq (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         push,
  input  scfnc_pkg::item_t  push_item,
  output logic              full,
  input  wire logic         pop,
  output logic              valid,
  output scfnc_pkg::item_t  head
);
  import scfnc_pkg::*;

  item_t              q_r [MIDQ_DEPTH];
  logic [MIDQ_AW-1:0] wp_r, rp_r;
  logic [MIDQ_CW-1:0] cnt_r, cnt_nxt;
  logic               do_push, do_pop;

  assign full    = (cnt_r == MIDQ_CW'(MIDQ_DEPTH));
  assign valid   = (cnt_r != '0);
  assign head    = q_r[rp_r];
  assign do_push = push & ~full;
  assign do_pop  = pop & valid;

  always_comb begin
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + MIDQ_CW'(1);
    end else if (!do_push && do_pop) begin
      cnt_nxt = cnt_r - MIDQ_CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      q_r[wp_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) wp_r <= wp_r + MIDQ_AW'(1);
      if (do_pop)  rp_r <= rp_r + MIDQ_AW'(1);
      cnt_r <= cnt_nxt;
    end
  end

endmodule
`default_nettype wire

>>> rtl/scfnc_back.sv
// Back part: newline folding, position tracking and the comment scanner.
`default_nettype none
module scfnc_back (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          valid,
  input  scfnc_pkg::item_t   it,
  input  wire logic          room2,
  output logic               take,
  output logic [1:0]         wr_n,
  output scfnc_pkg::result_t res0,
  output scfnc_pkg::result_t res1
);
  import scfnc_pkg::*;

  mode_t              mode_r, mode_nxt;
  nl_t                nl_r, nl_nxt;
  logic               held_r, held_nxt;
  logic [LINE_W-1:0]  hline_r, hline_nxt, line_r, line_nxt, la;
  logic [COL_W-1:0]   hcol_r, hcol_nxt, col_r, col_nxt, ca;
  logic [DEPTH_W-1:0] depth_r, depth_nxt;
  logic               start_r, start_nxt;
  logic               is_char, swallow, step, fin_end, opened, too_deep, examine, clear;

  assign take     = valid & room2;
  assign is_char  = take & ~it.is_end;
  assign swallow  = is_char & (((nl_r == NL_CR) && it.is_lf) || ((nl_r == NL_LF) && it.is_cr));
  assign step     = is_char & ~swallow;
  assign fin_end  = take & it.is_end;
  assign opened   = step && (mode_r == MODE_PLAIN) && held_r && it.m_os;
  assign too_deep = step && (mode_r == MODE_OPEN1) && it.m_os &&
                    (depth_r >= DEPTH_W'(MAX_DEPTH));
  assign examine  = step && ((mode_r == MODE_CMT) ||
                             ((mode_r == MODE_CLOSE1) && !it.m_cs) ||
                             ((mode_r == MODE_OPEN1) && !it.m_os));
  assign clear    = fin_end | too_deep;

  always_comb begin
    if (start_r) begin
      la = (line_r == LINE_TOP) ? line_r : line_r + LINE_W'(1);
      ca = COL_W'(1);
    end else begin
      la = line_r;
      ca = (col_r == COL_TOP) ? col_r : col_r + COL_W'(1);
    end
  end

  always_comb begin
    mode_nxt = mode_r;
    if (clear) begin
      mode_nxt = MODE_PLAIN;
    end else if (examine) begin
      priority if (it.m_cf) begin
        mode_nxt = MODE_CLOSE1;
      end else if (it.m_of) begin
        mode_nxt = MODE_OPEN1;
      end else begin
        mode_nxt = MODE_CMT;
      end
    end else if (step) begin
      unique case (mode_r)
        MODE_PLAIN:  if (opened) mode_nxt = MODE_CMT;
        MODE_CLOSE1: mode_nxt = (depth_r == '0) ? MODE_PLAIN : MODE_CMT;
        MODE_OPEN1:  mode_nxt = MODE_CMT;
        MODE_CMT:    mode_nxt = MODE_CMT;
        default:     mode_nxt = MODE_PLAIN;
      endcase
    end
  end

  always_comb begin
    nl_nxt    = nl_r;
    held_nxt  = held_r;
    hline_nxt = hline_r;
    hcol_nxt  = hcol_r;
    line_nxt  = line_r;
    col_nxt   = col_r;
    depth_nxt = depth_r;
    start_nxt = start_r;
    wr_n      = 2'd0;
    res0      = '{ch: 8'd0, line: la, col: ca, kind: KIND_CHAR, last: 1'b1};
    res1      = '{ch: 8'd0, line: la, col: ca, kind: KIND_END, last: 1'b1};
    if (fin_end) begin
      if (mode_r != MODE_PLAIN) begin
        res0.kind = KIND_EOF_CMT;
        wr_n      = 2'd1;
      end else if (held_r) begin
        res0 = '{ch: it.of_val, line: hline_r, col: hcol_r, kind: KIND_CHAR, last: 1'b0};
        wr_n = 2'd2;
      end else begin
        res0.kind = KIND_END;
        wr_n      = 2'd1;
      end
    end else if (swallow) begin
      nl_nxt = NL_NONE;
    end else if (step) begin
      nl_nxt    = it.is_cr ? NL_CR : (it.is_lf ? NL_LF : NL_NONE);
      line_nxt  = la;
      col_nxt   = ca;
      start_nxt = it.is_cr | it.is_lf;
      unique case (mode_r)
        MODE_PLAIN: begin
          if (opened) begin
            held_nxt  = 1'b0;
            depth_nxt = '0;
          end else begin
            held_nxt = it.m_of;
            if (it.m_of) begin
              hline_nxt = la;
              hcol_nxt  = ca;
            end
            if (held_r) begin
              res0 = '{ch: it.of_val, line: hline_r, col: hcol_r, kind: KIND_CHAR,
                       last: it.m_of};
              res1 = '{ch: it.ch, line: la, col: ca, kind: KIND_CHAR, last: 1'b1};
              wr_n = it.m_of ? 2'd1 : 2'd2;
            end else if (!it.m_of) begin
              res0.ch = it.ch;
              wr_n    = 2'd1;
            end
          end
        end
        MODE_CLOSE1: begin
          if (it.m_cs && (depth_r != '0)) depth_nxt = depth_r - DEPTH_W'(1);
        end
        MODE_OPEN1: begin
          if (it.m_os) begin
            if (too_deep) begin
              res0.kind = KIND_TOO_DEEP;
              wr_n      = 2'd1;
            end else begin
              depth_nxt = depth_r + DEPTH_W'(1);
            end
          end
        end
        MODE_CMT: ;
        default: ;
      endcase
    end
    if (clear) begin
      nl_nxt    = NL_NONE;
      held_nxt  = 1'b0;
      depth_nxt = '0;
      line_nxt  = '0;
      col_nxt   = '0;
      start_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    hline_r <= hline_nxt;
    hcol_r  <= hcol_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_PLAIN;
      nl_r    <= NL_NONE;
      held_r  <= 1'b0;
      line_r  <= '0;
      col_r   <= '0;
      depth_r <= '0;
      start_r <= 1'b1;
    end else begin
      mode_r  <= mode_nxt;
      nl_r    <= nl_nxt;
      held_r  <= held_nxt;
      line_r  <= line_nxt;
      col_r   <= col_nxt;
      depth_r <= depth_nxt;
      start_r <= start_nxt;
    end
  end

`ifndef SYNTHESIS
  a_held_plain: assert property (@(posedge clk) disable iff (!rst_n)
    held_r |-> (mode_r == MODE_PLAIN))
    else $error("held opener outside plain text");
  a_clear_state: assert property (@(posedge clk) disable iff (!rst_n)
    clear |=> (mode_r == MODE_PLAIN) && !held_r && (line_r == '0) && start_r)
    else $error("state not cleared after end or error");
  a_swallow_nl: assert property (@(posedge clk) disable iff (!rst_n)
    swallow |=> (nl_r == NL_NONE))
    else $error("newline pair not retired");
  a_end_result: assert property (@(posedge clk) disable iff (!rst_n)
    fin_end |-> (wr_n != 2'd0))
    else $error("end of input gave no result");
`endif

endmodule
`default_nettype wire

>>> rtl/scfnc_outq.sv
// Result queue taking up to two results per cycle and giving one per pop.
`default_nettype none
module scfnc_outq (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic [1:0]    wr_n,
  input  scfnc_pkg::result_t w0,
  input  scfnc_pkg::result_t w1,
  output logic               room2,
  input  wire logic          pop,
  output logic               empty,
  output scfnc_pkg::result_t head
);
  import scfnc_pkg::*;

  result_t            q_r [OUTQ_DEPTH];
  logic [OUTQ_AW-1:0] wp_r, rp_r;
  logic [OUTQ_CW-1:0] cnt_r;
  logic               do_pop;

  assign empty  = (cnt_r == '0);
  assign room2  = (cnt_r <= OUTQ_CW'(OUTQ_DEPTH - 2));
  assign head   = q_r[rp_r];
  assign do_pop = pop & ~empty;

  always_ff @(posedge clk) begin
    if (wr_n != 2'd0) q_r[wp_r] <= w0;
    if (wr_n == 2'd2) q_r[wp_r + OUTQ_AW'(1)] <= w1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_r + OUTQ_AW'(wr_n);
      if (do_pop) rp_r <= rp_r + OUTQ_AW'(1);
      cnt_r <= cnt_r + OUTQ_CW'(wr_n) - OUTQ_CW'(do_pop);
    end
  end

endmodule
`default_nettype wire

>>> rtl/source_char_filter_nested_comments_unit.sv
// Top level of the nested comment filter with line and column tracking.
// Usage: raw bytes enter on the input queue port (in_push while in_full is low);
// in_end marks end of input and carries no byte. Results leave on the output
// queue port: while out_empty is low the oldest result is on out_char, out_line,
// out_column, out_kind and out_last, and out_pop takes it.
// Marker bytes are written through cfg_we, cfg_index and cfg_data while idle.
// A beat accepted into the item queue is scanned from there, and its results
// are registered in the result queue before they can be popped.
// Throughput: one input beat and one result beat per cycle while in_full is low
// and the scanner has room. For an item giving two results, the scanner writes both at once.
// The scanner takes an item only when the result queue has room for two.
// Reset clears both queues and all scan state and loads the default markers;
// there is no clearing pass. When the receiver stalls the result queue fills,
// the scanner stops, the item queue fills and in_full rises.
`default_nettype none
module source_char_filter_nested_comments_unit (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [7:0]  cfg_data,
  input  wire logic        in_push,
  output logic             in_full,
  input  wire logic [7:0]  in_byte,
  input  wire logic        in_end,
  output logic             out_empty,
  input  wire logic        out_pop,
  output logic [7:0]       out_char,
  output logic [23:0]      out_line,
  output logic [15:0]      out_column,
  output logic [1:0]       out_kind,
  output logic             out_last
);
  import scfnc_pkg::*;

  item_t      fr_item, mid_head;
  logic       mid_valid, take, room2;
  logic [1:0] wr_n;
  result_t    res0, res1, head;

  scfnc_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_byte   (in_byte),
    .in_end    (in_end),
    .item      (fr_item)
  );

  scfnc_midq u_midq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_push),
    .push_item (fr_item),
    .full      (in_full),
    .pop       (take),
    .valid     (mid_valid),
    .head      (mid_head)
  );

  scfnc_back u_back (
    .clk   (clk),
    .rst_n (rst_n),
    .valid (mid_valid),
    .it    (mid_head),
    .room2 (room2),
    .take  (take),
    .wr_n  (wr_n),
    .res0  (res0),
    .res1  (res1)
  );

  scfnc_outq u_outq (
    .clk   (clk),
    .rst_n (rst_n),
    .wr_n  (wr_n),
    .w0    (res0),
    .w1    (res1),
    .room2 (room2),
    .pop   (out_pop),
    .empty (out_empty),
    .head  (head)
  );

  assign out_char   = head.ch;
  assign out_line   = head.line;
  assign out_column = head.col;
  assign out_kind   = head.kind;
  assign out_last   = head.last;

endmodule
`default_nettype wire

>>> bench/comment_filter_checker.sv
// Checker for the nested comment filter: predicts every result and compares it on the way out.
`timescale 1ns / 100ps
module comment_filter_checker
  import scfnc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data,
  input  logic        in_push,
  input  logic        in_full,
  input  logic [7:0]  in_byte,
  input  logic        in_end,
  input  logic        out_empty,
  input  logic        out_pop,
  input  logic [7:0]  out_char,
  input  logic [23:0] out_line,
  input  logic [15:0] out_column,
  input  logic [1:0]  out_kind,
  input  logic        out_last,
  output int          mismatch_total,
  output int          results_owed
);

  logic [7:0]        mk_of, mk_os, mk_cf, mk_cs;
  nl_t               nl;
  mode_t             mode;
  logic              held;
  logic [LINE_W-1:0] held_ln;
  logic [COL_W-1:0]  held_col;
  int                depth;
  logic [LINE_W-1:0] line_cnt;
  logic [COL_W-1:0]  col_cnt;
  logic              at_start;
  result_t           predicted_results [$];
  int                errs = 0;

  task automatic clear_scan();
    nl = NL_NONE;
    mode = MODE_PLAIN;
    held = 1'b0;
    held_ln = '0;
    held_col = '0;
    depth = 0;
    line_cnt = '0;
    col_cnt = '0;
    at_start = 1'b1;
  endtask

  task automatic step_position();
    if (at_start) begin
      if (line_cnt < LINE_TOP) line_cnt++;
      col_cnt = COL_W'(1);
      at_start = 1'b0;
    end else if (col_cnt < COL_TOP) begin
      col_cnt++;
    end
  endtask

  function automatic result_t make_res(logic [7:0] ch, logic [LINE_W-1:0] ln,
                                       logic [COL_W-1:0] cl, kind_t k);
    result_t r;
    r.ch = ch;
    r.line = ln;
    r.col = cl;
    r.kind = k;
    r.last = 1'b0;
    return r;
  endfunction

  task automatic strip_step(input logic [7:0] b, input logic e);
    result_t           produced [3];
    int                n;
    logic [7:0]        c;
    logic [LINE_W-1:0] ln;
    logic [COL_W-1:0]  cl;
    logic              rescan;
    n = 0;
    rescan = 1'b0;
    if (e) begin
      step_position();
      if (mode != MODE_PLAIN) begin
        produced[n] = make_res(8'd0, line_cnt, col_cnt, KIND_EOF_CMT);
        n++;
      end else begin
        if (held) begin
          produced[n] = make_res(mk_of, held_ln, held_col, KIND_CHAR);
          n++;
        end
        produced[n] = make_res(8'd0, line_cnt, col_cnt, KIND_END);
        n++;
      end
      clear_scan();
    end else if ((nl == NL_CR && b == CH_LF) || (nl == NL_LF && b == CH_CR)) begin
      nl = NL_NONE;
    end else begin
      nl = NL_NONE;
      c = b;
      if (b == CH_CR) begin
        nl = NL_CR;
        c = CH_LF;
      end else if (b == CH_LF) begin
        nl = NL_LF;
      end
      step_position();
      ln = line_cnt;
      cl = col_cnt;
      if (c == CH_LF) at_start = 1'b1;
      case (mode)
        MODE_PLAIN: begin
          if (held && c == mk_os) begin
            held = 1'b0;
            mode = MODE_CMT;
            depth = 0;
          end else begin
            if (held) begin
              held = 1'b0;
              produced[n] = make_res(mk_of, held_ln, held_col, KIND_CHAR);
              n++;
            end
            if (c == mk_of) begin
              held = 1'b1;
              held_ln = ln;
              held_col = cl;
            end else begin
              produced[n] = make_res(c, ln, cl, KIND_CHAR);
              n++;
            end
          end
        end
        MODE_CLOSE1: begin
          if (c == mk_cs) begin
            if (depth == 0) begin
              mode = MODE_PLAIN;
            end else begin
              depth--;
              mode = MODE_CMT;
            end
          end else begin
            rescan = 1'b1;
          end
        end
        MODE_OPEN1: begin
          if (c == mk_os) begin
            if (depth >= MAX_DEPTH) begin
              produced[n] = make_res(8'd0, ln, cl, KIND_TOO_DEEP);
              n++;
              clear_scan();
            end else begin
              depth++;
              mode = MODE_CMT;
            end
          end else begin
            rescan = 1'b1;
          end
        end
        default: rescan = 1'b1;
      endcase
      if (rescan) begin
        if (c == mk_cf) mode = MODE_CLOSE1;
        else if (c == mk_of) mode = MODE_OPEN1;
        else mode = MODE_CMT;
      end
    end
    for (int i = 0; i < n; i++) begin
      produced[i].last = (i == n - 1);
      predicted_results.push_back(produced[i]);
    end
  endtask

  task automatic cmp_field(input string name, input int unsigned want, input int unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      errs++;
    end
  endtask

  task automatic check_result();
    result_t want;
    if (predicted_results.size() == 0) begin
      $error("unexpected result beat: out_char %0d out_kind %0d", out_char, out_kind);
      errs++;
    end else begin
      want = predicted_results.pop_front();
      cmp_field("out_char", want.ch, out_char);
      cmp_field("out_line", want.line, out_line);
      cmp_field("out_column", want.col, out_column);
      cmp_field("out_kind", want.kind, out_kind);
      cmp_field("out_last", want.last, out_last);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      mk_of = OPEN_FIRST_RST;
      mk_os = OPEN_SECOND_RST;
      mk_cf = CLOSE_FIRST_RST;
      mk_cs = CLOSE_SECOND_RST;
      clear_scan();
      predicted_results.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_index))
          CFG_OPEN_FIRST:   mk_of = cfg_data;
          CFG_OPEN_SECOND:  mk_os = cfg_data;
          CFG_CLOSE_FIRST:  mk_cf = cfg_data;
          CFG_CLOSE_SECOND: mk_cs = cfg_data;
          default: ;
        endcase
      end
      if (out_pop && !out_empty) check_result();
      if (in_push && !in_full) strip_step(in_byte, in_end);
    end
    results_owed <= predicted_results.size();
    mismatch_total <= errs;
  end

endmodule

>>> bench/tb_top.sv
// Top of the nested comment filter testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps
module tb_top;
  import scfnc_pkg::*;

  localparam int CYCLE_LIMIT = 100000;
  localparam logic [8:0] EOS = 9'h100;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [7:0]  cfg_data = '0;
  logic        in_push = 1'b0;
  logic        in_full;
  logic [7:0]  in_byte = '0;
  logic        in_end = 1'b0;
  logic        out_empty;
  logic        out_pop = 1'b0;
  logic [7:0]  out_char;
  logic [23:0] out_line;
  logic [15:0] out_column;
  logic [1:0]  out_kind;
  logic        out_last;
  int          mismatch_total;
  int          results_owed;

  logic [7:0] of_mk = OPEN_FIRST_RST;
  logic [7:0] os_mk = OPEN_SECOND_RST;
  logic [7:0] cf_mk = CLOSE_FIRST_RST;
  logic [7:0] cs_mk = CLOSE_SECOND_RST;
  int         push_gap_pct = 0;
  int         pop_gap_pct = 0;
  int         pop_stall_left = 0;
  int         cycle_count = 0;

  logic [8:0] intro [$] = '{
    9'h000, 9'h0FF, {1'b0, OPEN_FIRST_RST}, 9'h071,
    {1'b0, CH_CR}, {1'b0, CH_LF}, {1'b0, CH_LF}, {1'b0, CH_CR},
    {1'b0, CH_CR}, {1'b0, CH_CR},
    {1'b0, OPEN_FIRST_RST}, {1'b0, OPEN_SECOND_RST},
    {1'b0, OPEN_FIRST_RST}, {1'b0, OPEN_SECOND_RST}, {1'b0, CH_LF},
    {1'b0, CLOSE_FIRST_RST}, {1'b0, CLOSE_SECOND_RST},
    {1'b0, CLOSE_FIRST_RST}, {1'b0, CLOSE_SECOND_RST},
    {1'b0, OPEN_FIRST_RST}, {1'b0, OPEN_SECOND_RST},
    {1'b0, CLOSE_FIRST_RST}, {1'b0, CLOSE_SECOND_RST},
    {1'b0, OPEN_FIRST_RST}, EOS,
    {1'b0, OPEN_FIRST_RST}, {1'b0, OPEN_SECOND_RST}, 9'h07A, EOS
  };

  always #10 clk = ~clk;

  source_char_filter_nested_comments_unit uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_push    (in_push),
    .in_full    (in_full),
    .in_byte    (in_byte),
    .in_end     (in_end),
    .out_empty  (out_empty),
    .out_pop    (out_pop),
    .out_char   (out_char),
    .out_line   (out_line),
    .out_column (out_column),
    .out_kind   (out_kind),
    .out_last   (out_last)
  );

  comment_filter_checker chk (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_push        (in_push),
    .in_full        (in_full),
    .in_byte        (in_byte),
    .in_end         (in_end),
    .out_empty      (out_empty),
    .out_pop        (out_pop),
    .out_char       (out_char),
    .out_line       (out_line),
    .out_column     (out_column),
    .out_kind       (out_kind),
    .out_last       (out_last),
    .mismatch_total (mismatch_total),
    .results_owed   (results_owed)
  );

  always @(posedge clk) begin
    if (!rst_n) begin
      out_pop <= 1'b0;
      pop_stall_left = 0;
    end else if (pop_stall_left > 0) begin
      out_pop <= 1'b0;
      pop_stall_left--;
    end else if (pop_gap_pct > 0 && $urandom_range(0, 99) < pop_gap_pct) begin
      out_pop <= 1'b0;
      pop_stall_left = $urandom_range(0, 16);
    end else begin
      out_pop <= 1'b1;
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic send_beat(input logic [7:0] b, input logic e);
    if (push_gap_pct > 0 && $urandom_range(0, 99) < push_gap_pct) begin
      in_push <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    in_push <= 1'b1;
    in_byte <= b;
    in_end <= e;
    do @(posedge clk); while (in_full);
  endtask

  task automatic send_pair(input logic [7:0] a, input logic [7:0] b);
    send_beat(a, 1'b0);
    send_beat(b, 1'b0);
  endtask

  task automatic drain();
    in_push <= 1'b0;
    do @(posedge clk); while (results_owed != 0);
  endtask

  task automatic settle();
    drain();
    repeat (10) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [7:0] v);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    @(posedge clk);
  endtask

  task automatic set_markers(input logic [7:0] a, input logic [7:0] b,
                             input logic [7:0] c, input logic [7:0] d);
    write_reg(CFG_OPEN_FIRST, a);
    write_reg(CFG_OPEN_SECOND, b);
    write_reg(CFG_CLOSE_FIRST, c);
    write_reg(CFG_CLOSE_SECOND, d);
    cfg_we <= 1'b0;
    of_mk = a;
    os_mk = b;
    cf_mk = c;
    cs_mk = d;
  endtask

  task automatic random_run(input int count);
    int pick;
    repeat (count) begin
      pick = $urandom_range(0, 99);
      if (pick < 25) begin
        send_beat(8'($urandom), 1'b0);
      end else if (pick < 40) begin
        case ($urandom_range(0, 3))
          0: send_beat(of_mk, 1'b0);
          1: send_beat(os_mk, 1'b0);
          2: send_beat(cf_mk, 1'b0);
          default: send_beat(cs_mk, 1'b0);
        endcase
      end else if (pick < 57) begin
        send_pair(of_mk, os_mk);
      end else if (pick < 72) begin
        send_pair(cf_mk, cs_mk);
      end else if (pick < 82) begin
        case ($urandom_range(0, 3))
          0: send_beat(CH_CR, 1'b0);
          1: send_beat(CH_LF, 1'b0);
          2: send_pair(CH_CR, CH_LF);
          default: send_pair(CH_LF, CH_CR);
        endcase
      end else if (pick < 93) begin
        send_beat(8'h61 + 8'($urandom_range(0, 25)), 1'b0);
      end else if (pick < 97) begin
        send_beat(8'($urandom), 1'b1);
      end else begin
        drain();
      end
    end
    send_beat(8'($urandom), 1'b1);
    settle();
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    push_gap_pct = 25;
    pop_gap_pct = 25;
    foreach (intro[i]) begin
      if (intro[i] == EOS) send_beat(8'($urandom), 1'b1);
      else send_beat(intro[i][7:0], 1'b0);
    end
    settle();

    set_markers(8'h00, 8'hFF, 8'hFF, 8'h00);
    push_gap_pct = 15 * $urandom_range(0, 3);
    pop_gap_pct = 15 * $urandom_range(0, 3);
    random_run(10);

    set_markers(8'hFF, 8'hFF, 8'hFF, 8'hFF);
    push_gap_pct = 15 * $urandom_range(0, 3);
    pop_gap_pct = 15 * $urandom_range(0, 3);
    random_run(10);

    set_markers(CH_LF, 8'h2F, 8'h2F, CH_LF);
    push_gap_pct = 40;
    pop_gap_pct = 40;
    random_run(10);

    repeat (2) begin
      set_markers(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
      push_gap_pct = 15 * $urandom_range(0, 3);
      pop_gap_pct = 15 * $urandom_range(0, 3);
      random_run(10);
    end

    set_markers(OPEN_FIRST_RST, OPEN_SECOND_RST, CLOSE_FIRST_RST, CLOSE_SECOND_RST);
    push_gap_pct = 20;
    pop_gap_pct = 20;
    random_run(10);

    push_gap_pct = 0;
    pop_gap_pct = 0;
    random_run(10);

    if (mismatch_total == 0 && results_owed == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/scfnc_pkg.sv
rtl/scfnc_front.sv
rtl/scfnc_midq.sv
rtl/scfnc_back.sv
rtl/scfnc_outq.sv
rtl/source_char_filter_nested_comments_unit.sv
bench/comment_filter_checker.sv
bench/tb_top.sv
